### src/rte_pkg.sv
`default_nettype none

package rte_pkg;

  localparam int KNOTS     = 13;
  localparam int FRAC_BITS = 8;
  localparam int RANGE_W   = 18;
  localparam int ENERGY_W  = 20;
  localparam int X_W       = RANGE_W + 16 - FRAC_BITS;
  localparam int KSEG_W    = $clog2(KNOTS - 1);
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 32;

  localparam longint LIM = 64'sd1 <<< 60;

  typedef longint coef_arr_t [KNOTS];

  typedef enum logic [2:0] {
    COEF_XQ,
    COEF_Y,
    COEF_B,
    COEF_C,
    COEF_D
  } coef_sel_t;

  typedef struct packed {
    logic [KSEG_W-1:0] k;
    logic [X_W-1:0]    tmag;
    logic              tneg;
    logic              oot;
  } rte_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                oot;
    logic                sat;
  } rte_result_t;

  localparam coef_arr_t KNOT_UM = '{
    70437, 127937, 237894, 472636, 757880, 2209170, 3044410,
    4822350, 7614610, 12356700, 17084500, 35343800, 44147600};
  localparam coef_arr_t KNOT_MEV = '{
    10, 14, 20, 30, 40, 80, 100, 140, 200, 300, 400, 800, 1000};

  function automatic longint mulq(longint a, longint b, int sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic         neg;
    ua  = (a < 0) ? 64'(64'd0 - 64'(a)) : 64'(a);
    ub  = (b < 0) ? 64'(64'd0 - 64'(b)) : 64'(b);
    neg = (a < 0) != (b < 0);
    p   = {64'd0, ua} * {64'd0, ub};
    if (p[127:64] != 64'd0) begin
      p = 128'(LIM);
    end else begin
      p = p >> sh;
      if (p > 128'(LIM)) begin
        p = 128'(LIM);
      end
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint adds(longint a, longint b);
    longint s;
    s = a + b;
    if (s > LIM) s = LIM;
    if (s < -LIM) s = -LIM;
    return s;
  endfunction

  // Evaluated at elaboration only; the spline coefficients become constant tables.
  function automatic coef_arr_t spline_coef(coef_sel_t sel);
    longint Xq [KNOTS];
    longint Sl [KNOTS];
    longint Cp [KNOTS];
    longint Dp [KNOTS];
    longint M2 [KNOTS];
    coef_arr_t Cy;
    coef_arr_t Cb;
    coef_arr_t Cc;
    coef_arr_t Cd;
    coef_arr_t res;
    longint A;
    longint C;
    longint Den;
    longint R;
    longint H;
    longint Six_h;
    for (int i = 0; i < KNOTS; i++) begin
      Xq[i] = (KNOT_UM[i] * 65536 + 50000) / 100000;
      Cy[i] = KNOT_MEV[i] * (64'sd1 <<< 32);
      Sl[i] = 0;
      Cp[i] = 0;
      Dp[i] = 0;
      M2[i] = 0;
      Cb[i] = 0;
      Cc[i] = 0;
      Cd[i] = 0;
    end
    for (int i = 0; i + 1 < KNOTS; i++) begin
      H = Xq[i+1] - Xq[i];
      if (H < 1) H = 1;
      Sl[i] = ((KNOT_MEV[i+1] - KNOT_MEV[i]) * (64'sd1 <<< 48)) / H;
    end
    for (int i = 1; i + 1 < KNOTS; i++) begin
      A = Xq[i] - Xq[i-1];
      if (A < 1) A = 1;
      C = Xq[i+1] - Xq[i];
      if (C < 1) C = 1;
      Den = 2 * (A + C) - mulq(A, Cp[i-1], 30);
      R = 6 * (Sl[i] - Sl[i-1]);
      if (Den < 1) Den = 1;
      Cp[i] = (C * (64'sd1 <<< 30)) / Den;
      Dp[i] = (adds(R, -mulq(A, Dp[i-1], 16)) * 65536) / Den;
    end
    for (int i = KNOTS - 2; i >= 1; i--) begin
      M2[i] = adds(Dp[i], -mulq(Cp[i], M2[i+1], 30));
    end
    for (int i = 0; i + 1 < KNOTS; i++) begin
      H = Xq[i+1] - Xq[i];
      if (H < 1) H = 1;
      Six_h = 6 * H;
      Cb[i] = adds(Sl[i], -(mulq(H, 2 * M2[i] + M2[i+1], 16) / 6));
      Cc[i] = M2[i] / 2;
      Cd[i] = ((M2[i+1] - M2[i]) * 65536) / Six_h;
    end
    case (sel)
      COEF_XQ: res = Xq;
      COEF_Y:  res = Cy;
      COEF_B:  res = Cb;
      COEF_C:  res = Cc;
      COEF_D:  res = Cd;
      default: res = Xq;
    endcase
    return res;
  endfunction

  localparam coef_arr_t XQ_TAB = spline_coef(COEF_XQ);
  localparam coef_arr_t CY_TAB = spline_coef(COEF_Y);
  localparam coef_arr_t CB_TAB = spline_coef(COEF_B);
  localparam coef_arr_t CC_TAB = spline_coef(COEF_C);
  localparam coef_arr_t CD_TAB = spline_coef(COEF_D);

endpackage

`default_nettype wire

### src/rte_front.sv
`default_nettype none

module rte_front import rte_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [RANGE_W-1:0] range_q,
  output logic                    q_push,
  output rte_item_t               q_item,
  input  wire logic               q_pop
);

  localparam int RES_W = $clog2(MID_DEPTH + 1);

  logic [RES_W-1:0]  res_cnt;
  logic [RES_W-1:0]  res_cnt_next;
  logic              accept;

  logic              v1;
  logic [X_W-1:0]    x1;
  logic              v2;
  logic [X_W-1:0]    x2;
  logic [KSEG_W-1:0] k2;
  logic              oot2;
  logic              v3;
  rte_item_t         item3;

  logic [KSEG_W-1:0] k_calc;
  logic              oot_calc;
  logic signed [X_W:0] diff;

  assign full   = (res_cnt == RES_W'(MID_DEPTH));
  assign accept = push && !full;

  // Slots in the queue are reserved at acceptance, so the front never has to stall.
  always_comb begin
    res_cnt_next = res_cnt;
    if (accept && !q_pop) begin
      res_cnt_next = res_cnt + RES_W'(1);
    end else if (!accept && q_pop) begin
      res_cnt_next = res_cnt - RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else begin
      res_cnt <= res_cnt_next;
    end
  end

  always_comb begin
    k_calc = '0;
    for (int j = 1; j < KNOTS - 1; j++) begin
      k_calc = k_calc + KSEG_W'(x1 >= X_W'(XQ_TAB[j]));
    end
    oot_calc = (x1 < X_W'(XQ_TAB[0])) || (x1 > X_W'(XQ_TAB[KNOTS-1]));
  end

  assign diff = $signed({1'b0, x2}) - $signed({1'b0, X_W'(XQ_TAB[k2])});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x1         <= X_W'(range_q) << (16 - FRAC_BITS);
    x2         <= x1;
    k2         <= k_calc;
    oot2       <= oot_calc;
    item3.k    <= k2;
    item3.oot  <= oot2;
    item3.tneg <= diff[X_W];
    item3.tmag <= diff[X_W] ? X_W'(-diff) : X_W'(diff);
  end

  assign q_push = v3;
  assign q_item = item3;

`ifndef SYNTHESIS
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_W'(MID_DEPTH))
    else $error("queue reservation count exceeds depth");
  a_push_reserved: assert property (@(posedge clk) disable iff (rst)
    q_push |-> res_cnt != '0)
    else $error("item reaches the queue without a reserved slot");
`endif

endmodule

`default_nettype wire

### src/rte_queue.sv
`default_nettype none

module rte_queue import rte_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire rte_item_t push_item,
  input  wire logic      pop,
  output logic           empty,
  output rte_item_t      head
);

  localparam int PTR_W = $clog2(MID_DEPTH);
  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  rte_item_t        mem [MID_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign empty  = (count == '0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && count == CNT_W'(MID_DEPTH)) |-> do_pop)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

### src/rte_step.sv
`default_nettype none

module rte_step import rte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire rte_item_t            in_item,
  input  wire logic signed [63:0]   in_acc,
  output logic [KSEG_W-1:0]         coef_k,
  input  wire logic signed [63:0]   coef,
  output logic                      out_valid,
  output rte_item_t                 out_item,
  output logic signed [63:0]        out_acc
);

  localparam int PP_W  = X_W + 32;
  localparam int SUM_W = X_W + 64;
  localparam int MAG_W = 61;

  localparam logic signed [64:0] LIM_P = 65'(LIM);
  localparam logic signed [64:0] LIM_N = -65'(LIM);

  logic              s1_v;
  rte_item_t         s1_item;
  logic [63:0]       s1_bmag;
  logic              s1_neg;
  logic              s2_v;
  rte_item_t         s2_item;
  logic [PP_W-1:0]   s2_pp_lo;
  logic [PP_W-1:0]   s2_pp_hi;
  logic              s2_neg;
  logic              s3_v;
  rte_item_t         s3_item;
  logic signed [MAG_W:0] s3_prod;

  logic [SUM_W-1:0]      sum;
  logic [MAG_W-1:0]      mag;
  logic signed [MAG_W:0] prod;
  logic signed [64:0]    acc_sum;
  logic signed [64:0]    acc_sat;

  // Magnitude product split in two 32-bit halves; any product of 2^64 or more saturates.
  always_comb begin
    sum  = {s2_pp_hi, 32'd0} + SUM_W'(s2_pp_lo);
    mag  = (|sum[SUM_W-1:64]) ? MAG_W'(LIM) : MAG_W'(sum[63:16]);
    prod = s2_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    acc_sum = 65'(coef) + 65'(s3_prod);
    acc_sat = acc_sum;
    if (acc_sum > LIM_P) begin
      acc_sat = LIM_P;
    end else if (acc_sum < LIM_N) begin
      acc_sat = LIM_N;
    end
  end

  assign coef_k = s3_item.k;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_item  <= in_item;
    s1_bmag  <= in_acc[63] ? 64'(64'd0 - 64'(in_acc)) : 64'(in_acc);
    s1_neg   <= in_item.tneg ^ in_acc[63];
    s2_item  <= s1_item;
    s2_neg   <= s1_neg;
    s2_pp_lo <= PP_W'(s1_item.tmag) * PP_W'(s1_bmag[31:0]);
    s2_pp_hi <= PP_W'(s1_item.tmag) * PP_W'(s1_bmag[63:32]);
    s3_item  <= s2_item;
    s3_prod  <= prod;
    out_item <= s3_item;
    out_acc  <= 64'(acc_sat);
  end

`ifndef SYNTHESIS
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_acc <= 64'(LIM) && out_acc >= -64'(LIM)))
    else $error("accumulator left the saturation range");
  a_zero_product: assert property (@(posedge clk) disable iff (rst)
    (s3_v && $past(s1_item.tmag, 2) == '0) |-> s3_prod == '0)
    else $error("zero offset gave a nonzero product");
`endif

endmodule

`default_nettype wire

### src/rte_back.sv
`default_nettype none

module rte_back import rte_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire rte_item_t      q_item,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic [ENERGY_W-1:0] kinetic_energy,
  output logic                out_of_table,
  output logic                saturated
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int RND_W = 62;
  localparam int SH    = 32 - FRAC_BITS;
  localparam int E_W   = RND_W - SH;

  logic                st_valid [4];
  rte_item_t           st_item  [4];
  logic signed [63:0]  st_acc   [4];
  logic [KSEG_W-1:0]   st_k     [3];
  logic signed [63:0]  st_coef  [3];

  logic [CNT_W-1:0]    out_res;
  logic [CNT_W-1:0]    out_cnt;
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  rte_result_t         out_mem [OUT_DEPTH];
  logic                do_pop;
  logic                take;

  logic                rv;
  rte_result_t         rres;
  rte_result_t         res_calc;
  logic [RND_W-1:0]    rsum;
  logic [E_W-1:0]      e_full;

  // Each item entering the evaluator holds an output slot until it is popped.
  assign take   = !q_empty && (out_res != CNT_W'(OUT_DEPTH));
  assign q_pop  = take;
  assign empty  = (out_cnt == '0);
  assign do_pop = pop && !empty;

  assign st_valid[0] = take;
  assign st_item[0]  = q_item;
  assign st_acc[0]   = CD_TAB[q_item.k];
  assign st_coef[0]  = CC_TAB[st_k[0]];
  assign st_coef[1]  = CB_TAB[st_k[1]];
  assign st_coef[2]  = CY_TAB[st_k[2]];

  rte_step u_step0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[0]),
    .in_item   (st_item[0]),
    .in_acc    (st_acc[0]),
    .coef_k    (st_k[0]),
    .coef      (st_coef[0]),
    .out_valid (st_valid[1]),
    .out_item  (st_item[1]),
    .out_acc   (st_acc[1])
  );

  rte_step u_step1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[1]),
    .in_item   (st_item[1]),
    .in_acc    (st_acc[1]),
    .coef_k    (st_k[1]),
    .coef      (st_coef[1]),
    .out_valid (st_valid[2]),
    .out_item  (st_item[2]),
    .out_acc   (st_acc[2])
  );

  rte_step u_step2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[2]),
    .in_item   (st_item[2]),
    .in_acc    (st_acc[2]),
    .coef_k    (st_k[2]),
    .coef      (st_coef[2]),
    .out_valid (st_valid[3]),
    .out_item  (st_item[3]),
    .out_acc   (st_acc[3])
  );

  // Round half up to the output fraction, then clamp to the field.
  always_comb begin
    rsum         = {1'b0, st_acc[3][60:0]} + (RND_W'(1) << (SH - 1));
    e_full       = rsum[RND_W-1:SH];
    res_calc.oot = st_item[3].oot;
    if (st_acc[3][63]) begin
      res_calc.energy = '0;
      res_calc.sat    = 1'b1;
    end else if (|e_full[E_W-1:ENERGY_W]) begin
      res_calc.energy = '1;
      res_calc.sat    = 1'b1;
    end else begin
      res_calc.energy = e_full[ENERGY_W-1:0];
      res_calc.sat    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rres <= res_calc;
    if (rv) begin
      out_mem[wr_ptr] <= rres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv      <= 1'b0;
      out_res <= '0;
      out_cnt <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
    end else begin
      rv <= st_valid[3];
      if (take && !do_pop) begin
        out_res <= out_res + CNT_W'(1);
      end else if (!take && do_pop) begin
        out_res <= out_res - CNT_W'(1);
      end
      if (rv && !do_pop) begin
        out_cnt <= out_cnt + CNT_W'(1);
      end else if (!rv && do_pop) begin
        out_cnt <= out_cnt - CNT_W'(1);
      end
      if (rv) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  assign kinetic_energy = out_mem[rd_ptr].energy;
  assign out_of_table   = out_mem[rd_ptr].oot;
  assign saturated      = out_mem[rd_ptr].sat;

`ifndef SYNTHESIS
  a_res_covers: assert property (@(posedge clk) disable iff (rst)
    out_res >= out_cnt)
    else $error("output occupancy exceeds reserved slots");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (rv && out_cnt == CNT_W'(OUT_DEPTH)) |-> do_pop)
    else $error("result written into a full output queue");
`endif

endmodule

`default_nettype wire

### src/range_to_energy_cubic_spline_core.sv
`default_nettype none

// Converts an 18-bit track range (cm, 8 fraction bits) into a muon kinetic energy
// (MeV, 8 fraction bits) through a natural cubic spline over 13 fixed knots; ranges
// outside the knot span are extrapolated with the end segment and flagged by
// out_of_table, and a clamped result is flagged by saturated. Both sides are queues:
// an item is taken whenever push is high and full is low, and results leave in order
// one per pop. The block sustains one item per clock while full stays low. On the way
// from acceptance to the visible result, with the queues empty, an item passes the
// segment search registers, the middle queue, the three Horner steps (each step is a
// four-stage multiply-add whose 26 by 64 bit product is built from two 32-bit halves),
// a register for rounding and clamping and the write into the output queue. The output
// queue holds 32 items; results that are not popped stop the intake only once all 32
// slots are committed. There is no startup sequence after reset.
module range_to_energy_cubic_spline_core import rte_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [RANGE_W-1:0]  range_q,
  output logic                     empty,
  input  wire logic                pop,
  output logic [ENERGY_W-1:0]      kinetic_energy,
  output logic                     out_of_table,
  output logic                     saturated
);

  logic      q_push;
  rte_item_t q_push_item;
  logic      q_pop;
  logic      q_empty;
  rte_item_t q_head;

  rte_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .range_q (range_q),
    .q_push  (q_push),
    .q_item  (q_push_item),
    .q_pop   (q_pop)
  );

  rte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  rte_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_item         (q_head),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .kinetic_energy (kinetic_energy),
    .out_of_table   (out_of_table),
    .saturated      (saturated)
  );

endmodule

`default_nettype wire

### verif/range_to_energy_cubic_spline_core_tb.sv
`timescale 1ns / 1ps

module range_to_energy_cubic_spline_core_tb;
  import rte_pkg::*;

  localparam int     NK        = 13;
  localparam longint CAP       = 64'sd1 <<< 60;
  localparam int     E_MAX     = 1048575;
  localparam int     ITEMS     = 1500;
  localparam int     NPROBE    = 23;
  localparam int     PRINT_CAP = 200;

  localparam longint KNOT_RANGE_E5 [NK] = '{
    70437, 127937, 237894, 472636, 757880, 2209170, 3044410,
    4822350, 7614610, 12356700, 17084500, 35343800, 44147600};
  localparam longint KNOT_MEV_TAB [NK] = '{
    10, 14, 20, 30, 40, 80, 100, 140, 200, 300, 400, 800, 1000};

  typedef struct packed {
    logic [RANGE_W-1:0] rq;
    logic               pinned;
    logic               oot;
  } range_probe_t;

  localparam range_probe_t PROBES [NPROBE] = '{
    '{18'd0,      1'b1, 1'b1},
    '{18'd1,      1'b1, 1'b1},
    '{18'd180,    1'b1, 1'b1},
    '{18'd181,    1'b1, 1'b0},
    '{18'd327,    1'b0, 1'b0},
    '{18'd328,    1'b0, 1'b0},
    '{18'd609,    1'b0, 1'b0},
    '{18'd610,    1'b0, 1'b0},
    '{18'd1940,   1'b0, 1'b0},
    '{18'd5655,   1'b0, 1'b0},
    '{18'd5656,   1'b0, 1'b0},
    '{18'd12345,  1'b0, 1'b0},
    '{18'd31633,  1'b0, 1'b0},
    '{18'd43736,  1'b0, 1'b0},
    '{18'd87381,  1'b0, 1'b0},
    '{18'd90480,  1'b0, 1'b0},
    '{18'd90481,  1'b0, 1'b0},
    '{18'd113017, 1'b1, 1'b0},
    '{18'd113018, 1'b1, 1'b1},
    '{18'd131072, 1'b1, 1'b1},
    '{18'd174762, 1'b1, 1'b1},
    '{18'd200000, 1'b1, 1'b1},
    '{18'd262143, 1'b1, 1'b1}};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [RANGE_W-1:0]  range_q = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [ENERGY_W-1:0] kinetic_energy;
  logic                out_of_table;
  logic                saturated;

  longint knot_x [NK];
  longint seg_y [NK];
  longint seg_b [NK];
  longint seg_c [NK];
  longint seg_d [NK];

  rte_result_t energy_due [$];
  int          errors = 0;
  bit          calm = 1'b0;

  range_to_energy_cubic_spline_core u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .range_q       (range_q),
    .empty         (empty),
    .pop           (pop),
    .kinetic_energy(kinetic_energy),
    .out_of_table  (out_of_table),
    .saturated     (saturated)
  );

  always #10 clk = ~clk;

  function automatic longint sat_mul_shr(longint a, longint b, int sh);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] mag;
    ma  = (a < 0) ? 64'(-a) : 64'(a);
    mb  = (b < 0) ? 64'(-b) : 64'(b);
    mag = {64'd0, ma} * {64'd0, mb};
    if (mag[127:64] != 64'd0) begin
      mag = 128'(CAP);
    end else begin
      mag = mag >> sh;
      if (mag > 128'(CAP)) mag = 128'(CAP);
    end
    return ((a < 0) != (b < 0)) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > CAP) s = CAP;
    else if (s < -CAP) s = -CAP;
    return s;
  endfunction

  function automatic longint seg_width(int k);
    longint w;
    w = knot_x[k+1] - knot_x[k];
    return (w < 1) ? 1 : w;
  endfunction

  function automatic rte_result_t range_energy(input logic [RANGE_W-1:0] rq);
    rte_result_t res;
    longint      x;
    longint      t;
    longint      acc;
    longint      rounded;
    int          k;
    x       = longint'(rq) <<< (16 - FRAC_BITS);
    res.oot = 1'b0;
    res.sat = 1'b0;
    if (x < knot_x[0]) begin
      k       = 0;
      res.oot = 1'b1;
    end else if (x > knot_x[NK-1]) begin
      k       = NK - 2;
      res.oot = 1'b1;
    end else begin
      k = 0;
      while (k < NK - 2 && knot_x[k+1] <= x) k++;
    end
    t   = x - knot_x[k];
    acc = seg_d[k];
    acc = sat_add(seg_c[k], sat_mul_shr(t, acc, 16));
    acc = sat_add(seg_b[k], sat_mul_shr(t, acc, 16));
    acc = sat_add(seg_y[k], sat_mul_shr(t, acc, 16));
    if (acc < 0) begin
      res.energy = '0;
      res.sat    = 1'b1;
    end else begin
      rounded = (acc + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
      if (rounded > E_MAX) begin
        res.energy = ENERGY_W'(E_MAX);
        res.sat    = 1'b1;
      end else begin
        res.energy = rounded[ENERGY_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic push_range(input logic [RANGE_W-1:0] rq, input logic pinned,
                            input logic pinned_oot);
    rte_result_t due;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 6) begin
      push    <= 1'b0;
      range_q <= RANGE_W'($urandom);
      @(negedge clk);
    end
    push    <= 1'b1;
    range_q <= rq;
    @(posedge clk);
    while (full) @(posedge clk);
    due = range_energy(rq);
    if (pinned) due.oot = pinned_oot;
    energy_due.push_back(due);
  endtask

  always @(negedge clk) pop <= calm || ($urandom_range(99) >= 6);

  always @(posedge clk) begin : check_results
    rte_result_t want;
    if (!rst && pop && !empty) begin
      if (energy_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing expected", kinetic_energy));
      end else begin
        want = energy_due.pop_front();
        if (kinetic_energy !== want.energy)
          flag_mismatch($sformatf("kinetic_energy %0d, expected %0d",
                                  kinetic_energy, want.energy));
        if (out_of_table !== want.oot)
          flag_mismatch($sformatf("out_of_table %b, expected %b", out_of_table, want.oot));
        if (saturated !== want.sat)
          flag_mismatch($sformatf("saturated %b, expected %b", saturated, want.sat));
      end
    end
  end

  initial begin
    longint             slope [NK];
    longint             piv [NK];
    longint             rhs [NK];
    longint             curv [NK];
    longint             wa;
    longint             wc;
    longint             den;
    int                 pick;
    int                 kn;
    int                 near;
    logic [RANGE_W-1:0] rq;

    // The spline is solved as a tridiagonal system with zero curvature at both ends.
    for (int i = 0; i < NK; i++) begin
      knot_x[i] = (KNOT_RANGE_E5[i] * 65536 + 50000) / 100000;
      seg_y[i]  = KNOT_MEV_TAB[i] <<< 32;
      slope[i]  = 0;
      piv[i]    = 0;
      rhs[i]    = 0;
      curv[i]   = 0;
      seg_b[i]  = 0;
      seg_c[i]  = 0;
      seg_d[i]  = 0;
    end
    for (int i = 0; i + 1 < NK; i++)
      slope[i] = ((KNOT_MEV_TAB[i+1] - KNOT_MEV_TAB[i]) * (64'sd1 <<< 48)) / seg_width(i);
    for (int i = 1; i + 1 < NK; i++) begin
      wa  = seg_width(i - 1);
      wc  = seg_width(i);
      den = 2 * (wa + wc) - sat_mul_shr(wa, piv[i-1], 30);
      if (den < 1) den = 1;
      piv[i] = (wc * (64'sd1 <<< 30)) / den;
      rhs[i] = (sat_add(6 * (slope[i] - slope[i-1]), -sat_mul_shr(wa, rhs[i-1], 16))
                * 65536) / den;
    end
    for (int i = NK - 2; i >= 1; i--)
      curv[i] = sat_add(rhs[i], -sat_mul_shr(piv[i], curv[i+1], 30));
    for (int i = 0; i + 1 < NK; i++) begin
      wa       = seg_width(i);
      seg_b[i] = sat_add(slope[i], -(sat_mul_shr(wa, 2 * curv[i] + curv[i+1], 16) / 6));
      seg_c[i] = curv[i] / 2;
      seg_d[i] = ((curv[i+1] - curv[i]) * 65536) / (6 * wa);
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (PROBES[i]) push_range(PROBES[i].rq, PROBES[i].pinned, PROBES[i].oot);

    for (int n = 0; n < ITEMS - NPROBE; n++) begin
      calm = (n >= 300 && n < 700);
      if (n == 900) begin
        @(negedge clk);
        push <= 1'b0;
        while (energy_due.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        rq = RANGE_W'($urandom_range(113017, 181));
      end else if (pick < 60) begin
        kn   = $urandom_range(NK - 1);
        near = int'(knot_x[kn] >>> 8) + int'($urandom_range(6)) - 3;
        if (near < 0) near = 0;
        rq = near[RANGE_W-1:0];
      end else if (pick < 70) begin
        rq = RANGE_W'($urandom_range(180));
      end else if (pick < 76) begin
        rq = RANGE_W'($urandom_range(113030, 113005));
      end else begin
        rq = RANGE_W'($urandom);
      end
      push_range(rq, 1'b0, 1'b0);
    end
    calm = 1'b0;

    @(negedge clk);
    push <= 1'b0;
    while (energy_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
